@@ src/sto_pkg.sv @@
// Package with shared constants and types of the sighting table.
package sto_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_PRUNE   = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [1:0] CLS_PROBE  = 2'd0;
    localparam logic [1:0] CLS_BEACON = 2'd1;
    localparam logic [1:0] CLS_ASSOC  = 2'd2;
    localparam logic [1:0] CLS_OTHER  = 2'd3;

    localparam logic CFG_IGNORE_LOCAL = 1'b0;
    localparam logic CFG_MIN_RSSI     = 1'b1;

    typedef struct packed {
        logic [63:0] ssid;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [7:0]  channel;
        logic [1:0]  cls;
        logic [31:0] seen_ts;
        logic [31:0] seen_cnt;
    } entry_t;

endpackage

@@ src/sto_mem.sv @@
// Entry memory of the sighting table with one write and one registered read port.
module sto_mem #(
    parameter int ENTRIES = sto_pkg::ENTRIES_DEF,
    parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  sto_pkg::entry_t      wdata,
    input  logic [AW-1:0]        raddr,
    output sto_pkg::entry_t      rdata
);
    import sto_pkg::*;

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/sto_div.sv @@
// Restoring divider for the prune threshold, one quotient bit per cycle.
module sto_div #(
    parameter int NW = 48,
    parameter int DW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import sto_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW:0]   rem_reg;
    logic [DW:0]   rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          done_reg;
    logic [DW+1:0] trial;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        quo_next = {quo_reg[NW-2:0], 1'b0};
        rem_next = trial[DW:0];
        if (trial >= {2'b00, den_reg})
        begin
            rem_next    = (DW+1)'(trial - {2'b00, den_reg});
            quo_next[0] = 1'b1;
        end
        cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_next == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ src/sighting_table_oldest_replace.sv @@
// Top level of the sighting table: sequencer that scans and rewrites the entry memory.
// Observe and query scan the table with one memory read per entry; prune runs a sum scan,
// a threshold division and then a compacting pass. Items are handled one at a time.
// Reset empties the table, clears the local MAC filter and sets the minimum RSSI to -128;
// the entry memory itself is not cleared and needs no clearing pass.
module sighting_table_oldest_replace #(
    parameter int ENTRIES = sto_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [63:0] ssid_key,
    input  logic [47:0] mac,
    input  logic signed [7:0] rssi,
    input  logic [7:0]  channel,
    input  logic [1:0]  frame_class,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [5:0]  slot,
    output logic        added,
    output logic        replaced,
    output logic        ignored,
    output logic [6:0]  entry_count,
    output logic [6:0]  removed_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import sto_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = 32 + CW;
    localparam int NW = SW + 4;
    localparam int DW = CW + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_HITRD  = 4'd2;
    localparam logic [3:0] ST_HITWR  = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_CMP    = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;
    localparam logic [3:0] ST_DIVGO  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic          ign_reg;
    logic [7:0]    minr_reg;

    logic [1:0]  act_reg;
    logic [63:0] key_reg;
    logic [47:0] mac_reg;
    logic [7:0]  rssi_reg;
    logic [7:0]  ch_reg;
    logic [1:0]  cls_reg;
    logic [31:0] ts_reg;

    // Scan: read address issued, and address of data arriving this cycle.
    logic [CW-1:0] ra_reg, ra_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic          rv_reg, rv_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [AW-1:0] old_reg, old_next;
    logic [31:0]   oldts_reg, oldts_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] nb_reg, nb_next;
    logic [NW-1:0] thr_reg;

    logic          found_reg, found_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          add_reg, add_next;
    logic          rep_reg, rep_next;
    logic          ign_o_reg, ign_o_next;
    logic [CW-1:0] rem_reg, rem_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata, newe;

    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;

    sto_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    sto_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    assign div_num = NW'({sum_reg, 2'b00}) + NW'({sum_reg, 1'b0}) + NW'(nb_reg);
    assign div_den = {nb_reg, 1'b0};

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        newe.ssid     = key_reg;
        newe.mac      = mac_reg;
        newe.rssi     = rssi_reg;
        newe.channel  = ch_reg;
        newe.cls      = cls_reg;
        newe.seen_ts  = ts_reg;
        newe.seen_cnt = 32'd1;
    end

    logic match;
    logic drop;
    always_comb
    begin
        unique case (cls_reg)
            CLS_PROBE:  match = (rdata.ssid == key_reg);
            CLS_BEACON,
            CLS_ASSOC:  match = (rdata.ssid == key_reg) &&
                                ((rdata.mac == mac_reg) || (rdata.cls != CLS_BEACON));
            default:    match = (rdata.mac == mac_reg);
        endcase
        drop = ((rdata.cls == CLS_BEACON) && (NW'(rdata.seen_cnt) < thr_reg)) ||
               ($signed(rdata.rssi) < $signed(minr_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        ra_next    = ra_reg;
        ri_next    = ri_reg;
        rv_next    = 1'b0;
        wp_next    = wp_reg;
        old_next   = old_reg;
        oldts_next = oldts_reg;
        sum_next   = sum_reg;
        nb_next    = nb_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        add_next   = add_reg;
        rep_next   = rep_reg;
        ign_o_next = ign_o_reg;
        rem_next   = rem_reg;
        we         = 1'b0;
        waddr      = AW'(ri_reg);
        wdata      = newe;
        raddr      = AW'(ra_reg);
        div_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ra_next = '0;
                ri_next = '0;
                wp_next = '0;
                sum_next = '0;
                nb_next  = '0;
                oldts_next = '1;
                old_next = '0;
                if (in_valid)
                begin
                    found_next = 1'b0;
                    slot_next  = '0;
                    add_next   = 1'b0;
                    rep_next   = 1'b0;
                    ign_o_next = 1'b0;
                    rem_next   = '0;
                    unique case (action)
                        ACT_OBSERVE:
                        begin
                            if (ign_reg && mac[41])
                            begin
                                ign_o_next = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_PRUNE:  state_next = ST_SUM;
                        ACT_CLEAR:
                        begin
                            used_next  = '0;
                            state_next = ST_OUT;
                        end
                        default:    state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Observe and query: one entry per cycle, memory data arriving in the cycle after its read address.
                if (ra_reg < used_reg)
                begin
                    ra_next = ra_reg + CW'(1);
                    rv_next = 1'b1;
                    ri_next = ra_reg;
                end
                if (rv_reg && ((act_reg == ACT_QUERY) ? (rdata.ssid == key_reg) : match))
                begin
                    found_next = 1'b1;
                    if (act_reg != ACT_QUERY)
                    begin
                        slot_next = AW'(ri_reg);
                    end
                    rv_next    = 1'b0;
                    state_next = (act_reg == ACT_QUERY) ? ST_OUT : ST_HITRD;
                    ra_next    = ri_reg;
                end
                else
                begin
                    if (rv_reg && (rdata.seen_ts < oldts_reg))
                    begin
                        oldts_next = rdata.seen_ts;
                        old_next   = AW'(ri_reg);
                    end
                    if (!rv_reg && !(ra_reg < used_reg))
                    begin
                        if (act_reg == ACT_QUERY)
                        begin
                            state_next = ST_OUT;
                        end
                        else if (used_reg < CW'(ENTRIES))
                        begin
                            we         = 1'b1;
                            waddr      = AW'(used_reg);
                            slot_next  = AW'(used_reg);
                            used_next  = used_reg + CW'(1);
                            add_next   = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = old_reg;
                            slot_next  = old_reg;
                            rep_next   = 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_HITRD:
            begin
                raddr      = slot_reg;
                state_next = ST_HITWR;
            end
            ST_HITWR:
            begin
                wdata = rdata;
                if ($signed(rssi_reg) > $signed(rdata.rssi))
                begin
                    wdata.rssi = rssi_reg;
                end
                if (cls_reg == CLS_BEACON || cls_reg == CLS_ASSOC)
                begin
                    wdata.channel = ch_reg;
                    wdata.mac     = mac_reg;
                end
                if (cls_reg == CLS_BEACON)
                begin
                    wdata.cls = cls_reg;
                end
                wdata.seen_ts = ts_reg;
                if (rdata.seen_cnt != '1)
                begin
                    wdata.seen_cnt = rdata.seen_cnt + 32'd1;
                end
                we         = 1'b1;
                waddr      = slot_reg;
                state_next = ST_OUT;
            end
            ST_SUM:
            begin
                if (ra_reg < used_reg)
                begin
                    ra_next = ra_reg + CW'(1);
                    rv_next = 1'b1;
                    ri_next = ra_reg;
                end
                if (rv_reg && rdata.cls == CLS_BEACON)
                begin
                    sum_next = sum_reg + SW'(rdata.seen_cnt);
                    nb_next  = nb_reg + CW'(1);
                end
                if (!rv_reg && !(ra_reg < used_reg))
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                if (nb_reg == '0)
                begin
                    state_next = ST_CMP;
                    ra_next    = '0;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ra_next = '0;
                if (div_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // Compaction: the write pointer never passes the read pointer.
                if (ra_reg < used_reg)
                begin
                    ra_next = ra_reg + CW'(1);
                    rv_next = 1'b1;
                    ri_next = ra_reg;
                end
                if (rv_reg && !drop)
                begin
                    we      = 1'b1;
                    waddr   = AW'(wp_reg);
                    wdata   = rdata;
                    wp_next = wp_reg + CW'(1);
                end
                if (!rv_reg && !(ra_reg < used_reg))
                begin
                    rem_next   = used_reg - wp_reg;
                    used_next  = wp_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            ign_reg   <= 1'b0;
            minr_reg  <= 8'h80;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            rv_reg    <= rv_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_IGNORE_LOCAL)
                begin
                    ign_reg <= cfg_data[0];
                end
                else
                begin
                    minr_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            key_reg  <= ssid_key;
            mac_reg  <= mac;
            rssi_reg <= rssi;
            ch_reg   <= channel;
            cls_reg  <= frame_class;
            ts_reg   <= timestamp;
        end
        if (state_reg == ST_DIVGO)
        begin
            thr_reg <= '0;
        end
        else if (div_done)
        begin
            thr_reg <= div_quo;
        end
        ra_reg    <= ra_next;
        ri_reg    <= ri_next;
        wp_reg    <= wp_next;
        old_reg   <= old_next;
        oldts_reg <= oldts_next;
        sum_reg   <= sum_next;
        nb_reg    <= nb_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        add_reg   <= add_next;
        rep_reg   <= rep_next;
        ign_o_reg <= ign_o_next;
        rem_reg   <= rem_next;
    end

    assign found         = found_reg;
    assign slot          = 6'(slot_reg);
    assign added         = add_reg;
    assign replaced      = rep_reg;
    assign ignored       = ign_o_reg;
    assign entry_count   = 7'(used_reg);
    assign removed_count = 7'(rem_reg);

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the sighting table with its own prediction of every result.
module tb;
    import sto_pkg::*;

    localparam int NSLOT = 64;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [63:0] ssid_key;
    logic [47:0] mac;
    logic signed [7:0] rssi;
    logic [7:0]  channel;
    logic [1:0]  frame_class;
    logic [31:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [5:0]  slot;
    logic        added;
    logic        replaced;
    logic        ignored;
    logic [6:0]  entry_count;
    logic [6:0]  removed_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    typedef struct packed {
        logic       found;
        logic [5:0] slot;
        logic       added;
        logic       replaced;
        logic       ignored;
        logic [6:0] entry_count;
        logic [6:0] removed_count;
    } outcome_t;

    entry_t     table_m [NSLOT];
    int         used_m;
    logic       ign_local_m;
    logic signed [7:0] min_rssi_m;
    outcome_t   pending_q[$];
    int         errors;
    bit         idle_on;
    bit         out_idle_on;
    logic [31:0] clock_s;

    sighting_table_oldest_replace u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("** sighting_table_oldest_replace: FAILED **");
        $finish;
    end

    function automatic bit entry_hit(entry_t e, logic [63:0] k, logic [47:0] m,
                                     logic [1:0] c);
        if (c == CLS_PROBE)
            return e.ssid == k;
        if (c == CLS_BEACON || c == CLS_ASSOC)
            return e.ssid == k && (e.mac == m || e.cls != CLS_BEACON);
        return e.mac == m;
    endfunction

    function automatic outcome_t predict_sighting(logic [1:0] a, logic [63:0] k,
                                                  logic [47:0] m, logic signed [7:0] r,
                                                  logic [7:0] ch, logic [1:0] c,
                                                  logic [31:0] ts);
        outcome_t o;
        int hit;
        int oldest;
        int w;
        logic [63:0] sum;
        logic [63:0] nb;
        logic [63:0] thr;
        bit drop;
        o = '0;
        if (a == ACT_OBSERVE)
        begin
            if (ign_local_m && m[41])
                o.ignored = 1'b1;
            else
            begin
                hit = used_m;
                for (int i = 0; i < used_m; i++)
                    if (hit == used_m && entry_hit(table_m[i], k, m, c))
                        hit = i;
                if (hit < used_m)
                begin
                    o.found = 1'b1;
                    o.slot = 6'(hit);
                    if (r > $signed(table_m[hit].rssi))
                        table_m[hit].rssi = r;
                    if (c == CLS_BEACON || c == CLS_ASSOC)
                    begin
                        table_m[hit].channel = ch;
                        table_m[hit].mac = m;
                    end
                    if (c == CLS_BEACON)
                        table_m[hit].cls = c;
                    table_m[hit].seen_ts = ts;
                    if (table_m[hit].seen_cnt != 32'hFFFF_FFFF)
                        table_m[hit].seen_cnt++;
                end
                else
                begin
                    if (used_m < NSLOT)
                    begin
                        hit = used_m;
                        used_m++;
                        o.added = 1'b1;
                    end
                    else
                    begin
                        oldest = 0;
                        for (int i = 1; i < used_m; i++)
                            if (table_m[i].seen_ts < table_m[oldest].seen_ts)
                                oldest = i;
                        hit = oldest;
                        o.replaced = 1'b1;
                    end
                    table_m[hit] = '{k, m, r, ch, c, ts, 32'd1};
                    o.slot = 6'(hit);
                end
            end
        end
        else if (a == ACT_PRUNE)
        begin
            sum = 0;
            nb = 0;
            thr = 0;
            w = 0;
            for (int i = 0; i < used_m; i++)
                if (table_m[i].cls == CLS_BEACON)
                begin
                    sum += table_m[i].seen_cnt;
                    nb++;
                end
            if (nb != 0)
                thr = (6 * sum + nb) / (2 * nb);
            for (int i = 0; i < used_m; i++)
            begin
                drop = (table_m[i].cls == CLS_BEACON && {32'd0, table_m[i].seen_cnt} < thr)
                       || $signed(table_m[i].rssi) < min_rssi_m;
                if (!drop)
                begin
                    table_m[w] = table_m[i];
                    w++;
                end
            end
            o.removed_count = 7'(used_m - w);
            used_m = w;
        end
        else if (a == ACT_CLEAR)
            used_m = 0;
        else
            for (int i = 0; i < used_m; i++)
                if (table_m[i].ssid == k)
                    o.found = 1'b1;
        o.entry_count = 7'(used_m);
        return o;
    endfunction

    task automatic idle_gap(bit on);
        if (on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_sighting(logic [1:0] a, logic [63:0] k, logic [47:0] m,
                                 logic [7:0] r, logic [7:0] ch, logic [1:0] c,
                                 logic [31:0] ts);
        idle_gap(idle_on);
        action <= a;
        ssid_key <= k;
        mac <= m;
        rssi <= r;
        channel <= ch;
        frame_class <= c;
        timestamp <= ts;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.insert(pending_q.size(), predict_sighting(a, k, m, r, ch, c, ts));
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_setting(logic idx, logic [7:0] val);
        drain_and_settle();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IGNORE_LOCAL)
            ign_local_m = val[0];
        else
            min_rssi_m = val;
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with no item waiting");
                    errors++;
                end
                else
                begin
                    outcome_t e;
                    e = pending_q.pop_front();
                    if (found !== e.found)
                    begin
                        $error("found: expected %0d, got %0d", e.found, found);
                        errors++;
                    end
                    if (slot !== e.slot)
                    begin
                        $error("slot: expected %0d, got %0d", e.slot, slot);
                        errors++;
                    end
                    if (added !== e.added)
                    begin
                        $error("added: expected %0d, got %0d", e.added, added);
                        errors++;
                    end
                    if (replaced !== e.replaced)
                    begin
                        $error("replaced: expected %0d, got %0d", e.replaced, replaced);
                        errors++;
                    end
                    if (ignored !== e.ignored)
                    begin
                        $error("ignored: expected %0d, got %0d", e.ignored, ignored);
                        errors++;
                    end
                    if (entry_count !== e.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d", e.entry_count,
                               entry_count);
                        errors++;
                    end
                    if (removed_count !== e.removed_count)
                    begin
                        $error("removed_count: expected %0d, got %0d", e.removed_count,
                               removed_count);
                        errors++;
                    end
                end
            end
            if (out_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [63:0] pick_key();
        return 64'($urandom_range(0, 11)) * 64'h9E37_79B9_7F4A_7C15;
    endfunction

    function automatic logic [47:0] pick_mac();
        logic [47:0] m;
        m = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
            m = {8'h02 & {8{$urandom_range(0, 1) == 1}}, 32'h0, 8'($urandom_range(0, 9))};
        return m;
    endfunction

    task automatic random_sighting(int pfill);
        logic [1:0] a;
        int p;
        p = $urandom_range(0, 99);
        if (p < pfill)
            a = ACT_OBSERVE;
        else if (p < pfill + 6)
            a = ACT_PRUNE;
        else if (p < pfill + 8)
            a = ACT_CLEAR;
        else
            a = ACT_QUERY;
        clock_s += $urandom_range(0, 3);
        send_sighting(a, pick_key(), pick_mac(), 8'($urandom), 8'($urandom),
                      2'($urandom), $urandom_range(0, 3) == 0 ? $urandom : clock_s);
    endtask

    task automatic test_directed();
        send_sighting(ACT_QUERY, '1, '1, 8'h7F, '1, CLS_PROBE, '1);
        send_sighting(ACT_PRUNE, '0, '0, 8'h80, '0, CLS_PROBE, '0);
        send_sighting(ACT_OBSERVE, '1, '1, 8'h80, '1, CLS_BEACON, '1);
        send_sighting(ACT_OBSERVE, '1, 48'h1, 8'h7F, 8'd6, CLS_BEACON, 32'd5);
        send_sighting(ACT_OBSERVE, '1, 48'h2, 8'h10, 8'd7, CLS_ASSOC, 32'd6);
        send_sighting(ACT_OBSERVE, 64'd3, 48'h2, 8'h10, 8'd7, CLS_ASSOC, 32'd7);
        send_sighting(ACT_OBSERVE, 64'd3, 48'h9, 8'h20, 8'd1, CLS_ASSOC, 32'd8);
        send_sighting(ACT_OBSERVE, '1, 48'h5, 8'h00, 8'd1, CLS_PROBE, 32'd9);
        send_sighting(ACT_OBSERVE, '0, 48'h1, 8'h00, 8'd1, CLS_OTHER, 32'd9);
        send_sighting(ACT_OBSERVE, '0, 48'h77, 8'h00, 8'd1, CLS_OTHER, 32'd0);
        send_sighting(ACT_QUERY, '1, '0, '0, '0, CLS_PROBE, '0);
        send_sighting(ACT_QUERY, 64'd4, '0, '0, '0, CLS_PROBE, '0);
        send_sighting(ACT_PRUNE, '0, '0, '0, '0, CLS_PROBE, '0);
        send_sighting(ACT_CLEAR, '0, '0, '0, '0, CLS_PROBE, '0);
        send_sighting(ACT_QUERY, '1, '0, '0, '0, CLS_PROBE, '0);
        for (int i = 0; i < 66; i++)
            send_sighting(ACT_OBSERVE, 64'(i), 48'(i), 8'(i), 8'd1, 2'(i),
                          i == 64 ? 32'd0 : 32'(100 - i));
    endtask

    task automatic test_local_macs();
        write_setting(CFG_IGNORE_LOCAL, 8'd1);
        send_sighting(ACT_OBSERVE, 64'd1, 48'h0200_0000_0000, 8'd0, 8'd1, CLS_PROBE, 32'd1);
        send_sighting(ACT_OBSERVE, 64'd1, 48'hFD00_0000_0000, 8'd0, 8'd1, CLS_PROBE, 32'd1);
        for (int i = 0; i < 60; i++)
            random_sighting(80);
        write_setting(CFG_IGNORE_LOCAL, 8'd0);
    endtask

    task automatic test_min_rssi();
        logic [7:0] levels[3] = '{8'h7F, 8'h00, 8'hF0};
        foreach (levels[j])
        begin
            write_setting(CFG_MIN_RSSI, levels[j]);
            for (int i = 0; i < 40; i++)
                random_sighting(80);
            send_sighting(ACT_PRUNE, '0, '0, '0, '0, CLS_PROBE, '0);
        end
        write_setting(CFG_MIN_RSSI, 8'h80);
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 390; i++)
        begin
            if (i == 330)
            begin
                idle_on = 1'b0;
                out_idle_on = 1'b0;
            end
            random_sighting(i % 150 < 100 ? 88 : 70);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        ssid_key = '0;
        mac = '0;
        rssi = '0;
        channel = '0;
        frame_class = '0;
        timestamp = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        errors = 0;
        used_m = 0;
        ign_local_m = 1'b0;
        min_rssi_m = -8'sd128;
        clock_s = 32'd1000;
        idle_on = 1'b1;
        out_idle_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_local_macs();
        test_min_rssi();
        test_random_mix();
        drain_and_settle();
        if (errors == 0)
            $display("** sighting_table_oldest_replace: PASSED **");
        else
            $display("** sighting_table_oldest_replace: FAILED **");
        $finish;
    end
endmodule
